// ===== rtl/adsr_pkg.sv =====
// Shared constants, types and controller/datapath interface structs for the
// ADSR envelope generator. No dependencies.
package adsr_pkg;

  // Sizing of the tick counter and of the coefficient fraction
  localparam int COUNT_WIDTH    = 24;
  localparam int COEF_FRAC_BITS = 24;

  // Fixed widths of the register and stream fields
  localparam int LEN_W      = 24;
  localparam int COEF_W     = 24;
  localparam int LVL_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int IN_DATA_W  = 8;

  // Derived datapath widths
  localparam int SEQ_W   = COEF_FRAC_BITS + 1;
  localparam int MUL_A_W = COEF_W;
  localparam int MUL_B_W = SEQ_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int CMP_W   = (COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W;

  localparam logic [LVL_W-1:0] FULL_SCALE = 16'h8000;

  // Register reset values
  localparam logic [LEN_W-1:0]  RST_ATTACK_LEN = 24'd480;
  localparam logic [LEN_W-1:0]  RST_DECAY_LEN  = 24'd4800;
  localparam logic [LVL_W-1:0]  RST_SUSTAIN    = 16'd16384;
  localparam logic [COEF_W-1:0] RST_ATTACK_CF  = 24'd16672985;
  localparam logic [COEF_W-1:0] RST_DECAY_CF   = 24'd16766734;
  localparam logic [COEF_W-1:0] RST_RELEASE_CF = 24'd16766734;

  // Register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_ATTACK_LEN = 3'd0;
  localparam cfg_idx_t CFG_DECAY_LEN  = 3'd1;
  localparam cfg_idx_t CFG_SUSTAIN    = 3'd2;
  localparam cfg_idx_t CFG_ATTACK_CF  = 3'd3;
  localparam cfg_idx_t CFG_DECAY_CF   = 3'd4;
  localparam cfg_idx_t CFG_RELEASE_CF = 3'd5;

  // Envelope stage
  typedef enum logic [1:0] {
    STG_ATTACK  = 2'd0,
    STG_DECAY   = 2'd1,
    STG_SUSTAIN = 2'd2,
    STG_RELEASE = 2'd3
  } stage_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the input gate
    logic count;   // gate edges and tick counter
    logic adv;     // stage advance and sequence restarts
    logic seq;     // sequence step (first value or multiply)
    logic seq_wb;  // write back saturated sequence product
    logic lvl;     // level product
    logic fin;     // form level and load output register
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_seq;   // current stage steps its sequence
    logic seq_first;  // sequence restarts at one on this step
    logic out_busy;   // output register full and not taken this cycle
  } ctrl_sts_t;

endpackage

// ===== rtl/adsr_ctrl.sv =====
// Sequencing state machine of the ADSR envelope generator.
// Depends on adsr_pkg for the command and status structs.
module adsr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  adsr_pkg::ctrl_sts_t sts,
  output adsr_pkg::ctrl_cmd_t cmd
);
  import adsr_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_COUNT  = 7'b0000010,
    S_ADV    = 7'b0000100,
    S_SEQ    = 7'b0001000,
    S_SEQ_WB = 7'b0010000,
    S_LVL    = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_COUNT;
      S_COUNT:  state_nxt = S_ADV;
      S_ADV:    state_nxt = S_SEQ;
      S_SEQ: begin
        if (!sts.need_seq)      state_nxt = S_FIN;
        else if (sts.seq_first) state_nxt = S_LVL;
        else                    state_nxt = S_SEQ_WB;
      end
      S_SEQ_WB: state_nxt = S_LVL;
      S_LVL:    state_nxt = S_FIN;
      S_FIN:    if (!sts.out_busy) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Decode commands
  assign in_tready  = (state_r == S_IDLE);
  assign cmd.load   = (state_r == S_IDLE) && in_tvalid;
  assign cmd.count  = (state_r == S_COUNT);
  assign cmd.adv    = (state_r == S_ADV);
  assign cmd.seq    = (state_r == S_SEQ);
  assign cmd.seq_wb = (state_r == S_SEQ_WB);
  assign cmd.lvl    = (state_r == S_LVL);
  assign cmd.fin    = (state_r == S_FIN) && !sts.out_busy;

endmodule

// ===== rtl/adsr_dpath.sv =====
// Datapath of the ADSR envelope generator: registers, envelope state, shared
// multiplier and output register. Depends on adsr_pkg.
module adsr_dpath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  adsr_pkg::ctrl_cmd_t          cmd,
  output adsr_pkg::ctrl_sts_t          sts,
  input  logic                         cfg_we,
  input  adsr_pkg::cfg_idx_t           cfg_index,
  input  logic [adsr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                         gate_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [adsr_pkg::LVL_W-1:0]   out_level
);
  import adsr_pkg::*;

  localparam logic [1:0] SEQ_ATTACK  = 2'd0;
  localparam logic [1:0] SEQ_DECAY   = 2'd1;
  localparam logic [1:0] SEQ_RELEASE = 2'd2;

  localparam logic [SEQ_W-1:0] SEQ_ONE = {1'b1, {COEF_FRAC_BITS{1'b0}}};
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam int SH_W  = PROD_W - COEF_FRAC_BITS;
  localparam int SAT_W = (SH_W > SEQ_W) ? SH_W : SEQ_W;
  localparam int SUM_W = LVL_W + 2;

  function automatic logic [1:0] seq_of(stage_t s);
    logic [1:0] k;
    unique case (s)
      STG_DECAY:   k = SEQ_DECAY;
      STG_RELEASE: k = SEQ_RELEASE;
      default:     k = SEQ_ATTACK;
    endcase
    return k;
  endfunction

  // Configuration registers
  logic [LEN_W-1:0]  attack_len_r, decay_len_r;
  logic [LVL_W-1:0]  sustain_r;
  logic [COEF_W-1:0] coef_r [0:2];

  // Envelope state
  logic                   gate_r, gate_prev_r, cnt_r;
  stage_t                 stage_r, old_stage_r;
  logic [COUNT_WIDTH-1:0] elapsed_r;
  logic [LVL_W-1:0]       last_level_r, attack_start_r, decay_start_r, release_start_r;
  logic                   exp_first_r [0:2];
  logic [SEQ_W-1:0]       exp_value_r [0:2];
  logic [PROD_W-1:0]      prod_r;
  logic                   out_valid_r;
  logic [LVL_W-1:0]       level_r;

  // Write configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_len_r <= RST_ATTACK_LEN;
      decay_len_r  <= RST_DECAY_LEN;
      sustain_r    <= RST_SUSTAIN;
      coef_r[0]    <= RST_ATTACK_CF;
      coef_r[1]    <= RST_DECAY_CF;
      coef_r[2]    <= RST_RELEASE_CF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ATTACK_LEN: attack_len_r <= cfg_data[LEN_W-1:0];
        CFG_DECAY_LEN:  decay_len_r  <= cfg_data[LEN_W-1:0];
        CFG_SUSTAIN:    sustain_r    <= cfg_data[LVL_W-1:0];
        CFG_ATTACK_CF:  coef_r[0]    <= cfg_data[COEF_W-1:0];
        CFG_DECAY_CF:   coef_r[1]    <= cfg_data[COEF_W-1:0];
        CFG_RELEASE_CF: coef_r[2]    <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp sustain to full scale
  logic [LVL_W-1:0] sus;
  assign sus = (sustain_r > FULL_SCALE) ? FULL_SCALE : sustain_r;

  // Gate edges
  logic rise, fall, active;
  assign rise   = gate_r & ~gate_prev_r;
  assign fall   = ~gate_r & gate_prev_r;
  assign active = gate_r || (stage_r == STG_RELEASE);

  // Stage advance on counter overrun, excess ticks carried
  stage_t                 stage_nxt;
  logic [COUNT_WIDTH-1:0] elapsed_nxt;
  logic                   decay_ld;
  logic [CMP_W-1:0]       el_ext, alen_ext, dlen_ext;
  assign el_ext   = CMP_W'(elapsed_r);
  assign alen_ext = CMP_W'(attack_len_r);
  assign dlen_ext = CMP_W'(decay_len_r);

  always_comb begin
    stage_nxt   = stage_r;
    elapsed_nxt = elapsed_r;
    decay_ld    = 1'b0;
    if (cnt_r && stage_r == STG_ATTACK && el_ext > alen_ext) begin
      stage_nxt   = STG_DECAY;
      elapsed_nxt = COUNT_WIDTH'(el_ext - alen_ext);
      decay_ld    = 1'b1;
    end else if (cnt_r && stage_r == STG_DECAY && el_ext > dlen_ext) begin
      stage_nxt   = STG_SUSTAIN;
      elapsed_nxt = COUNT_WIDTH'(el_ext - dlen_ext);
    end
  end

  // Sequence of the current stage
  logic [1:0]       k;
  logic [SEQ_W-1:0] e_cur;
  logic             need_seq;
  assign k        = seq_of(stage_r);
  assign e_cur    = exp_value_r[k];
  assign need_seq = active && (stage_r != STG_SUSTAIN);

  // Level operand: distance covered by the current stage
  logic [LVL_W-1:0] lvl_opnd;
  always_comb begin
    unique case (stage_r)
      STG_ATTACK:  lvl_opnd = FULL_SCALE - attack_start_r;
      STG_DECAY:   lvl_opnd = (decay_start_r >= sus) ? (decay_start_r - sus)
                                                     : (sus - decay_start_r);
      STG_RELEASE: lvl_opnd = release_start_r;
      default:     lvl_opnd = '0;
    endcase
  end

  // Shared multiplier: sequence step, then level scaling
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_p;
  always_comb begin
    if (cmd.lvl) begin
      mul_a = MUL_A_W'(lvl_opnd);
      mul_b = (stage_r == STG_ATTACK) ? (SEQ_ONE - e_cur) : e_cur;
    end else begin
      mul_a = coef_r[k];
      mul_b = e_cur;
    end
  end
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Saturate the sequence product at one
  logic [SAT_W-1:0] seq_sh;
  logic [SEQ_W-1:0] seq_sat;
  assign seq_sh  = SAT_W'(prod_r >> COEF_FRAC_BITS);
  assign seq_sat = (seq_sh > SAT_W'(SEQ_ONE)) ? SEQ_ONE : SEQ_W'(seq_sh);

  // Form the output level
  logic [LVL_W:0]   p;
  logic [SUM_W-1:0] lvl_sum;
  logic [LVL_W-1:0] lvl_nxt;
  assign p = prod_r[COEF_FRAC_BITS +: LVL_W+1];
  always_comb begin
    lvl_sum = '0;
    if (active) begin
      unique case (stage_r)
        STG_ATTACK:  lvl_sum = SUM_W'(attack_start_r) + SUM_W'(p);
        STG_DECAY:   lvl_sum = (decay_start_r >= sus) ? SUM_W'(sus) + SUM_W'(p)
                                                      : SUM_W'(sus) - SUM_W'(p);
        STG_SUSTAIN: lvl_sum = SUM_W'(sus);
        default:     lvl_sum = SUM_W'(p);
      endcase
    end
  end
  assign lvl_nxt = (lvl_sum > SUM_W'(FULL_SCALE)) ? FULL_SCALE : LVL_W'(lvl_sum);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_prev_r <= 1'b0;
      stage_r     <= STG_ATTACK;
      old_stage_r <= STG_ATTACK;
      cnt_r       <= 1'b0;
      elapsed_r   <= '0;
      last_level_r <= '0;
      exp_first_r[0] <= 1'b1;
      exp_first_r[1] <= 1'b1;
      exp_first_r[2] <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      // Apply gate edges, else advance the saturating counter
      if (cmd.count) begin
        gate_prev_r <= gate_r;
        old_stage_r <= stage_r;
        cnt_r       <= 1'b0;
        if (rise) begin
          stage_r   <= STG_ATTACK;
          elapsed_r <= '0;
        end else if (fall) begin
          stage_r   <= STG_RELEASE;
          elapsed_r <= '0;
        end else if (active) begin
          cnt_r <= 1'b1;
          if (elapsed_r != COUNT_MAX) elapsed_r <= elapsed_r + 1'b1;
        end
      end
      // Advance stage; restart the sequence of a newly entered stage
      if (cmd.adv) begin
        stage_r   <= stage_nxt;
        elapsed_r <= elapsed_nxt;
        if (stage_nxt != old_stage_r && stage_nxt != STG_SUSTAIN)
          exp_first_r[seq_of(stage_nxt)] <= 1'b1;
      end
      if (cmd.seq && need_seq) exp_first_r[k] <= 1'b0;
      // Keep the level as the start point of the next stage
      if (cmd.fin) last_level_r <= lvl_nxt;
      // Hold the result until taken
      if (cmd.fin)        out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) gate_r <= gate_in;
    if (cmd.count) begin
      if (rise)      attack_start_r  <= last_level_r;
      else if (fall) release_start_r <= last_level_r;
    end
    if (cmd.adv && decay_ld) decay_start_r <= last_level_r;
    if (cmd.seq && need_seq) begin
      if (exp_first_r[k]) exp_value_r[k] <= SEQ_ONE;
      else                prod_r         <= mul_p;
    end
    if (cmd.seq_wb) exp_value_r[k] <= seq_sat;
    if (cmd.lvl)    prod_r         <= mul_p;
    if (cmd.fin)    level_r        <= lvl_nxt;
  end

  assign sts.need_seq  = need_seq;
  assign sts.seq_first = exp_first_r[k];
  assign sts.out_busy  = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_level     = level_r;

endmodule

// ===== rtl/adsr_envelope_generator.sv =====
// ADSR envelope generator, top level: stream ports, configuration port,
// controller and datapath. Depends on adsr_pkg, adsr_ctrl and adsr_dpath.
//
// One input transaction carries the gate bit of one sample tick and yields one
// output transaction with the envelope level (Q1.15, 32768 = 1.0). Items are
// worked one at a time: an input runs through the count, advance, sequence,
// write-back, level and finish states (no write-back when a stage sequence
// restarts at one; neither write-back nor level in sustain or idle), and the next
// input is taken once the result is loaded. The single shared multiplier does
// the sequence step and level scaling. The output register holds a result
// until taken; the block waits before loading a new one. Registers are to be
// written through cfg_* (always ready) while the block is idle; not enforced.
module adsr_envelope_generator (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] gate, [7:1] zero
  // Output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] level
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import adsr_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  adsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  adsr_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_idx_t'(cfg_index)),
    .cfg_data  (cfg_data),
    .gate_in   (in_tdata[0]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_level (out_tdata)
  );

  // Level never exceeds full scale
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata <= FULL_SCALE))
    else $error("envelope level above full scale");

  // One item in flight: no accept in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an item is in flight");

endmodule
